[sv/sljp_pkg.sv]
package sljp_pkg;

   localparam int unsigned PAYLOAD_LIMIT_DEFAULT = 512;

   localparam int unsigned MAX_LEN_W   = 10;
   localparam int unsigned INTERVAL_W  = 8;
   localparam int unsigned HB_COUNT_W  = 32;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned INDEX_W     = 9;
   localparam int unsigned FRAME_LEN_W = 16;
   localparam int unsigned KIND_W      = 3;

   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;
   // tdata: 82 field bits padded to 88
   localparam int unsigned TDATA_W = 88;
   localparam int unsigned TPAD_W  = 6;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;
   localparam logic [BYTE_W-1:0] HEARTBEAT_CMD = 8'h00;

   localparam logic [MAX_LEN_W-1:0]  MAX_LEN_RESET  = 10'd512;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd20;
   localparam logic [INTERVAL_W-1:0] INTERVAL_MIN   = 8'd2;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_MAX_LEN  = 1'b0;
   localparam logic CSR_IDX_INTERVAL = 1'b1;

   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_VER   = 3'd2,
      PH_CMD   = 3'd3,
      PH_LENHI = 3'd4,
      PH_LENLO = 3'd5,
      PH_DATA  = 3'd6,
      PH_CHECK = 3'd7
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_STRAY     = 3'd0,
      KIND_TOO_LONG  = 3'd1,
      KIND_PAYLOAD   = 3'd2,
      KIND_FRAME_END = 3'd3,
      KIND_HEARTBEAT = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [BYTE_W-1:0]       byte_value;
      logic [INDEX_W-1:0]      payload_index;
      logic [BYTE_W-1:0]       frame_version;
      logic [BYTE_W-1:0]       frame_command;
      logic [FRAME_LEN_W-1:0]  frame_length;
      logic                    sum_ok;
      logic [HB_COUNT_W-1:0]   heartbeat_total;
   } result_type;

   typedef struct packed {
      logic                    busy;
      logic [HB_COUNT_W-1:0]   count_next;
      logic [INTERVAL_W-1:0]   rem_next;
   } hb_status_type;

endpackage

[sv/sync_length_sum_frame_parser.sv]
// Frame parser for 0x55 0xAA | version | command | length (big endian, 16 bits) |
// payload | 8-bit sum. Takes one received byte per cycle on req_ while not held, and
// gives at most one result per byte on rsp_: stray bytes, oversize length, each
// payload byte, frame end with checksum status, and a heartbeat notice for a command-0
// frame whose new heartbeat total is 1 modulo an interval of at least 2. Sustained
// rate is one byte per clock while rsp_ is not stalled; a byte's result passes through
// the input register, then the output register with a one-entry skid behind it, so a
// stalled rsp_ side is absorbed for one result before req_tready drops. Writing
// heartbeat_interval holds the parser while the heartbeat count is reduced modulo the
// new interval, one counter byte per cycle; req_tready stays low in that time once a
// byte waits in the input register. Write registers only while no bytes are in flight.
module sync_length_sum_frame_parser #(
   parameter int unsigned PAYLOAD_LIMIT = sljp_pkg::PAYLOAD_LIMIT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sljp_pkg::BYTE_W-1:0]         req_tdata,   // [7:0] rx_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] byte_value, [16:8] payload_index, [24:17] frame_version,
   // [32:25] frame_command, [48:33] frame_length, [49] sum_ok,
   // [81:50] heartbeat_total, [87:82] zero
   output logic [sljp_pkg::TDATA_W-1:0]        rsp_tdata,
   output logic [sljp_pkg::KIND_W-1:0]         rsp_tuser,   // [2:0] kind
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sljp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sljp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sljp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [sljp_pkg::MAX_LEN_W-1:0]  max_len_ff;
   logic [sljp_pkg::INTERVAL_W-1:0] interval_ff;
   logic                            csr_write;
   logic                            csr_idx;
   logic                            interval_write;

   logic                         in_valid_ff;
   logic [sljp_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                         accept;
   logic                         step;

   sljp_pkg::hb_status_type hb;
   logic                    hb_bump;
   logic                    res_valid;
   sljp_pkg::result_type    res;

   logic                    out_valid_ff;
   sljp_pkg::result_type    out_ff;
   logic                    skid_valid_ff;
   sljp_pkg::result_type    skid_ff;
   logic                    out_free;

   // configuration
   assign csr_pready     = 1'b1;
   assign csr_idx        = csr_paddr[2];
   assign csr_write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign interval_write = csr_write && (csr_idx == sljp_pkg::CSR_IDX_INTERVAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff  <= sljp_pkg::MAX_LEN_RESET;
         interval_ff <= sljp_pkg::INTERVAL_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            sljp_pkg::CSR_IDX_MAX_LEN:  max_len_ff  <= csr_pwdata[sljp_pkg::MAX_LEN_W-1:0];
            sljp_pkg::CSR_IDX_INTERVAL: interval_ff <= csr_pwdata[sljp_pkg::INTERVAL_W-1:0];
            default:                    max_len_ff  <= max_len_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         sljp_pkg::CSR_IDX_MAX_LEN:  csr_prdata = sljp_pkg::CSR_DATA_W'(max_len_ff);
         sljp_pkg::CSR_IDX_INTERVAL: csr_prdata = sljp_pkg::CSR_DATA_W'(interval_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // input register; advance only while the skid slot is free and the heartbeat counter is not busy
   assign step       = in_valid_ff && !skid_valid_ff && !hb.busy;
   assign req_tready = !in_valid_ff || step;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
      end
   end

   sljp_parser #(
      .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .max_len   (max_len_ff),
      .interval  (interval_ff),
      .hb        (hb),
      .hb_bump   (hb_bump),
      .res_valid (res_valid),
      .res       (res)
   );

   sljp_hb_count u_hb_count (
      .clock    (clock),
      .reset    (reset),
      .interval (interval_ff),
      .start    (interval_write),
      .bump     (hb_bump),
      .status   (hb)
   );

   // output register with skid
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || res_valid;
         skid_valid_ff <= 1'b0;
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end else if (res_valid) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {{sljp_pkg::TPAD_W{1'b0}}, out_ff.heartbeat_total, out_ff.sum_ok,
                        out_ff.frame_length, out_ff.frame_command, out_ff.frame_version,
                        out_ff.payload_index, out_ff.byte_value};

endmodule

[sv/sljp_hb_count.sv]
// Heartbeat counter with its remainder modulo the interval kept alongside.
// A new interval restarts the remainder from the count, one byte per cycle.
module sljp_hb_count (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [sljp_pkg::INTERVAL_W-1:0]      interval,
   input  logic                                 start,
   input  logic                                 bump,
   output sljp_pkg::hb_status_type              status
);

   localparam int unsigned STEPS   = sljp_pkg::HB_COUNT_W / sljp_pkg::BYTE_W;
   localparam int unsigned STEP_W  = $clog2(STEPS);
   localparam int unsigned REM_W   = sljp_pkg::INTERVAL_W;

   logic [sljp_pkg::HB_COUNT_W-1:0] count_ff, count_in;
   logic [REM_W-1:0]                rem_ff, rem_in;
   logic                            busy_ff, busy_in;
   logic [STEP_W-1:0]               step_ff, step_in;
   logic [sljp_pkg::HB_COUNT_W-1:0] shift_ff, shift_in;

   logic [REM_W:0]   rem_inc;
   logic [REM_W-1:0] rem_wrap;
   logic [REM_W:0]   rem_work;

   assign rem_inc  = {1'b0, rem_ff} + 1'b1;
   assign rem_wrap = (rem_inc == {1'b0, interval}) ? '0 : rem_inc[REM_W-1:0];

   // eight restoring steps on the top byte of the shift register
   always_comb begin
      rem_work = {1'b0, rem_ff};
      for (int i = sljp_pkg::BYTE_W - 1; i >= 0; i--) begin
         rem_work = {rem_work[REM_W-1:0], shift_ff[sljp_pkg::HB_COUNT_W - sljp_pkg::BYTE_W + i]};
         if (rem_work >= {1'b0, interval}) begin
            rem_work = rem_work - {1'b0, interval};
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      rem_in   = rem_ff;
      busy_in  = busy_ff;
      step_in  = step_ff;
      shift_in = shift_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         rem_in   = '0;
         shift_in = count_ff;
      end else if (busy_ff) begin
         rem_in   = rem_work[REM_W-1:0];
         shift_in = shift_ff << sljp_pkg::BYTE_W;
         step_in  = step_ff + 1'b1;
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end else if (bump) begin
         count_in = count_ff + 1'b1;
         rem_in   = rem_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rem_ff   <= '0;
         busy_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         count_ff <= count_in;
         rem_ff   <= rem_in;
         busy_ff  <= busy_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign status.busy       = busy_ff;
   assign status.count_next = count_ff + 1'b1;
   assign status.rem_next   = rem_wrap;

endmodule

[sv/sljp_parser.sv]
// Per-byte frame parser: one byte per step, at most one result per step.
module sljp_parser #(
   parameter int unsigned PAYLOAD_LIMIT = sljp_pkg::PAYLOAD_LIMIT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [sljp_pkg::BYTE_W-1:0]        rx_byte,
   input  logic [sljp_pkg::MAX_LEN_W-1:0]     max_len,
   input  logic [sljp_pkg::INTERVAL_W-1:0]    interval,
   input  sljp_pkg::hb_status_type            hb,
   output logic                               hb_bump,
   output logic                               res_valid,
   output sljp_pkg::result_type               res
);

   localparam int unsigned REG_MAX   = (1 << sljp_pkg::MAX_LEN_W) - 1;
   localparam int unsigned LEN_LIMIT = (PAYLOAD_LIMIT < REG_MAX) ? PAYLOAD_LIMIT : REG_MAX;
   localparam int unsigned LEN_W     = $clog2(LEN_LIMIT + 1);
   localparam int unsigned CMP_W     = sljp_pkg::FRAME_LEN_W + 1;

   sljp_pkg::phase_type phase_ff, phase_in;
   logic [sljp_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [sljp_pkg::BYTE_W-1:0] version_ff, version_in;
   logic [sljp_pkg::BYTE_W-1:0] command_ff, command_in;
   logic [sljp_pkg::BYTE_W-1:0] len_high_ff, len_high_in;
   logic [LEN_W-1:0]            held_len_ff, held_len_in;
   logic [LEN_W-1:0]            count_ff, count_in;

   logic [sljp_pkg::BYTE_W-1:0]      sum_add;
   logic [sljp_pkg::FRAME_LEN_W-1:0] len_rx;
   logic [CMP_W-1:0]                 limit;
   logic                             len_zero;
   logic                             len_over;
   logic [LEN_W-1:0]                 count_inc;
   logic                             last_payload;
   logic [sljp_pkg::FRAME_LEN_W-1:0] held_len_ext;
   logic [sljp_pkg::FRAME_LEN_W-1:0] count_ext;
   logic                             sum_match;
   logic                             is_heartbeat;
   logic                             hb_notice;

   assign sum_add      = sum_ff + rx_byte;
   assign len_rx       = {len_high_ff, rx_byte};
   assign limit        = (CMP_W'(max_len) > CMP_W'(PAYLOAD_LIMIT))
                         ? CMP_W'(PAYLOAD_LIMIT) : CMP_W'(max_len);
   assign len_zero     = (len_rx == '0);
   assign len_over     = (CMP_W'(len_rx) > limit);
   assign count_inc    = count_ff + 1'b1;
   assign last_payload = (count_inc == held_len_ff);
   assign held_len_ext = sljp_pkg::FRAME_LEN_W'(held_len_ff);
   assign count_ext    = sljp_pkg::FRAME_LEN_W'(count_ff);
   assign sum_match    = (sum_ff == rx_byte);
   assign is_heartbeat = (command_ff == sljp_pkg::HEARTBEAT_CMD);
   assign hb_notice    = (interval >= sljp_pkg::INTERVAL_MIN) && (hb.rem_next == 8'd1);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            sljp_pkg::PH_SYNC1: begin
               if (rx_byte == sljp_pkg::SYNC_FIRST) phase_in = sljp_pkg::PH_SYNC2;
            end
            sljp_pkg::PH_SYNC2: begin
               if (rx_byte == sljp_pkg::SYNC_SECOND) begin
                  phase_in = sljp_pkg::PH_VER;
               end else if (rx_byte != sljp_pkg::SYNC_FIRST) begin
                  phase_in = sljp_pkg::PH_SYNC1;
               end
            end
            sljp_pkg::PH_VER:   phase_in = sljp_pkg::PH_CMD;
            sljp_pkg::PH_CMD:   phase_in = sljp_pkg::PH_LENHI;
            sljp_pkg::PH_LENHI: phase_in = sljp_pkg::PH_LENLO;
            sljp_pkg::PH_LENLO: begin
               if (len_zero) begin
                  phase_in = sljp_pkg::PH_CHECK;
               end else if (len_over) begin
                  phase_in = sljp_pkg::PH_SYNC1;
               end else begin
                  phase_in = sljp_pkg::PH_DATA;
               end
            end
            sljp_pkg::PH_DATA: begin
               if (last_payload) phase_in = sljp_pkg::PH_CHECK;
            end
            sljp_pkg::PH_CHECK: phase_in = sljp_pkg::PH_SYNC1;
            default:            phase_in = sljp_pkg::PH_SYNC1;
         endcase
      end
   end

   // datapath and results
   always_comb begin
      sum_in      = sum_ff;
      version_in  = version_ff;
      command_in  = command_ff;
      len_high_in = len_high_ff;
      held_len_in = held_len_ff;
      count_in    = count_ff;
      hb_bump     = 1'b0;
      res_valid   = 1'b0;
      res         = '0;
      if (step) begin
         case (phase_ff)
            sljp_pkg::PH_SYNC1: begin
               if (rx_byte == sljp_pkg::SYNC_FIRST) begin
                  sum_in = rx_byte;
               end else begin
                  res_valid      = 1'b1;
                  res.kind       = sljp_pkg::KIND_STRAY;
                  res.byte_value = rx_byte;
               end
            end
            sljp_pkg::PH_SYNC2: begin
               if (rx_byte == sljp_pkg::SYNC_SECOND) begin
                  sum_in = sum_add;
               end else if (rx_byte != sljp_pkg::SYNC_FIRST) begin
                  res_valid      = 1'b1;
                  res.kind       = sljp_pkg::KIND_STRAY;
                  res.byte_value = rx_byte;
               end
            end
            sljp_pkg::PH_VER: begin
               version_in = rx_byte;
               sum_in     = sum_add;
            end
            sljp_pkg::PH_CMD: begin
               command_in = rx_byte;
               sum_in     = sum_add;
            end
            sljp_pkg::PH_LENHI: begin
               len_high_in = rx_byte;
               sum_in      = sum_add;
            end
            sljp_pkg::PH_LENLO: begin
               sum_in   = sum_add;
               count_in = '0;
               if (len_zero) begin
                  held_len_in = '0;
               end else if (len_over) begin
                  res_valid         = 1'b1;
                  res.kind          = sljp_pkg::KIND_TOO_LONG;
                  res.frame_version = version_ff;
                  res.frame_command = command_ff;
                  res.frame_length  = len_rx;
               end else begin
                  held_len_in = LEN_W'(len_rx);
               end
            end
            sljp_pkg::PH_DATA: begin
               sum_in            = sum_add;
               count_in          = count_inc;
               res_valid         = 1'b1;
               res.kind          = sljp_pkg::KIND_PAYLOAD;
               res.byte_value    = rx_byte;
               res.payload_index = count_ext[sljp_pkg::INDEX_W-1:0];
               res.frame_version = version_ff;
               res.frame_command = command_ff;
               res.frame_length  = held_len_ext;
            end
            sljp_pkg::PH_CHECK: begin
               res.frame_version = version_ff;
               res.frame_command = command_ff;
               res.frame_length  = held_len_ext;
               res.sum_ok        = sum_match;
               if (is_heartbeat) begin
                  hb_bump             = 1'b1;
                  res_valid           = hb_notice;
                  res.kind            = sljp_pkg::KIND_HEARTBEAT;
                  res.heartbeat_total = hb.count_next;
               end else begin
                  res_valid = 1'b1;
                  res.kind  = sljp_pkg::KIND_FRAME_END;
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= sljp_pkg::PH_SYNC1;
         sum_ff      <= '0;
         version_ff  <= '0;
         command_ff  <= '0;
         len_high_ff <= '0;
         held_len_ff <= '0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         sum_ff      <= sum_in;
         version_ff  <= version_in;
         command_ff  <= command_in;
         len_high_ff <= len_high_in;
         held_len_ff <= held_len_in;
         count_ff    <= count_in;
      end
   end

endmodule

[sv/sljp_checker.sv]
module sljp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [sljp_pkg::TDATA_W-1:0]       rsp_tdata,
   input logic [sljp_pkg::KIND_W-1:0]        rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // checksum status only on frame end and heartbeat notices
   a_ok_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[49] |->
         rsp_tuser == sljp_pkg::KIND_FRAME_END || rsp_tuser == sljp_pkg::KIND_HEARTBEAT)
      else $error("sum_ok set on wrong kind");

   // stray bytes carry no frame context
   a_stray_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sljp_pkg::KIND_STRAY |-> rsp_tdata[87:8] == '0)
      else $error("stray byte carries frame fields");

   // heartbeat total only on notices
   a_total_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != sljp_pkg::KIND_HEARTBEAT |-> rsp_tdata[81:50] == '0)
      else $error("heartbeat_total set on wrong kind");

endmodule

bind sync_length_sum_frame_parser sljp_checker u_sljp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/sv/frame_result_checker.sv]
`timescale 1ns / 100ps

module frame_result_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [sljp_pkg::BYTE_W-1:0]      req_tdata,   // [7:0] rx_byte
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] byte_value, [16:8] payload_index, [24:17] frame_version,
   // [32:25] frame_command, [48:33] frame_length, [49] sum_ok,
   // [81:50] heartbeat_total, [87:82] zero
   input  logic [sljp_pkg::TDATA_W-1:0]     rsp_tdata,
   input  logic [sljp_pkg::KIND_W-1:0]      rsp_tuser,   // [2:0] kind
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sljp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sljp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                             csr_pready,
   output int                               failures,
   output int                               outstanding,
   output int                               results_checked,
   output int                               frames_closed,
   output int                               notices_seen
);
   import sljp_pkg::*;

   phase_type                parse_phase;
   logic [BYTE_W-1:0]        running_sum;
   logic [BYTE_W-1:0]        held_version;
   logic [BYTE_W-1:0]        held_command;
   logic [BYTE_W-1:0]        held_len_high;
   logic [MAX_LEN_W-1:0]     held_length;
   logic [MAX_LEN_W-1:0]     payload_count;
   logic [HB_COUNT_W-1:0]    beat_count;
   logic [MAX_LEN_W-1:0]     max_len;
   logic [INTERVAL_W-1:0]    interval;

   result_type               expected_results[$];

   task automatic queue_result(input kind_type kind, input logic [BYTE_W-1:0] value,
                               input logic [INDEX_W-1:0] index,
                               input logic [BYTE_W-1:0] version,
                               input logic [BYTE_W-1:0] command,
                               input logic [FRAME_LEN_W-1:0] length,
                               input logic ok, input logic [HB_COUNT_W-1:0] total);
      result_type r;
      r.kind            = kind;
      r.byte_value      = value;
      r.payload_index   = index;
      r.frame_version   = version;
      r.frame_command   = command;
      r.frame_length    = length;
      r.sum_ok          = ok;
      r.heartbeat_total = total;
      expected_results.push_back(r);
   endtask

   // advance the parser by one received byte and queue what it reports
   task automatic parse_rx_byte(input logic [BYTE_W-1:0] rx);
      logic [FRAME_LEN_W-1:0] length;
      int unsigned            limit;
      logic                   ok;
      case (parse_phase)
         PH_SYNC1: begin
            if (rx == SYNC_FIRST) begin
               running_sum = rx;
               parse_phase = PH_SYNC2;
            end else begin
               queue_result(KIND_STRAY, rx, '0, '0, '0, '0, 1'b0, '0);
            end
         end
         PH_SYNC2: begin
            if (rx == SYNC_SECOND) begin
               running_sum = running_sum + rx;
               parse_phase = PH_VER;
            end else if (rx != SYNC_FIRST) begin
               parse_phase = PH_SYNC1;
               queue_result(KIND_STRAY, rx, '0, '0, '0, '0, 1'b0, '0);
            end
         end
         PH_VER: begin
            held_version = rx;
            running_sum  = running_sum + rx;
            parse_phase  = PH_CMD;
         end
         PH_CMD: begin
            held_command = rx;
            running_sum  = running_sum + rx;
            parse_phase  = PH_LENHI;
         end
         PH_LENHI: begin
            held_len_high = rx;
            running_sum   = running_sum + rx;
            parse_phase   = PH_LENLO;
         end
         PH_LENLO: begin
            running_sum   = running_sum + rx;
            length        = {held_len_high, rx};
            payload_count = '0;
            limit = (max_len > PAYLOAD_LIMIT_DEFAULT) ? PAYLOAD_LIMIT_DEFAULT : max_len;
            if (length == 0) begin
               held_length = '0;
               parse_phase = PH_CHECK;
            end else if (length > limit) begin
               parse_phase = PH_SYNC1;
               queue_result(KIND_TOO_LONG, '0, '0, held_version, held_command, length,
                            1'b0, '0);
            end else begin
               held_length = length[MAX_LEN_W-1:0];
               parse_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            running_sum = running_sum + rx;
            queue_result(KIND_PAYLOAD, rx, payload_count[INDEX_W-1:0], held_version,
                         held_command, held_length, 1'b0, '0);
            payload_count = payload_count + 1'b1;
            if (payload_count >= held_length)
               parse_phase = PH_CHECK;
         end
         default: begin
            parse_phase = PH_SYNC1;
            ok = (running_sum == rx);
            if (held_command == HEARTBEAT_CMD) begin
               // counted even with a bad checksum
               beat_count = beat_count + 1'b1;
               if (interval >= INTERVAL_MIN) begin
                  if (beat_count % interval == 1)
                     queue_result(KIND_HEARTBEAT, '0, '0, held_version, held_command,
                                  held_length, ok, beat_count);
               end
            end else begin
               queue_result(KIND_FRAME_END, '0, '0, held_version, held_command,
                            held_length, ok, '0);
            end
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   task automatic check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         $error("result with nothing expected: kind %0d, tdata 0x%0h", rsp_tuser, rsp_tdata);
         failures++;
      end else begin
         want = expected_results.pop_front();
         compare_field("kind", want.kind, rsp_tuser);
         compare_field("byte_value", want.byte_value, rsp_tdata[7:0]);
         compare_field("payload_index", want.payload_index, rsp_tdata[16:8]);
         compare_field("frame_version", want.frame_version, rsp_tdata[24:17]);
         compare_field("frame_command", want.frame_command, rsp_tdata[32:25]);
         compare_field("frame_length", want.frame_length, rsp_tdata[48:33]);
         compare_field("sum_ok", want.sum_ok, rsp_tdata[49]);
         compare_field("heartbeat_total", want.heartbeat_total, rsp_tdata[81:50]);
         results_checked++;
         if (want.kind == KIND_FRAME_END)
            frames_closed++;
         if (want.kind == KIND_HEARTBEAT)
            notices_seen++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         parse_phase     = PH_SYNC1;
         running_sum     = '0;
         held_version    = '0;
         held_command    = '0;
         held_len_high   = '0;
         held_length     = '0;
         payload_count   = '0;
         beat_count      = '0;
         max_len         = MAX_LEN_RESET;
         interval        = INTERVAL_RESET;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == CSR_IDX_MAX_LEN)
               max_len = csr_pwdata[MAX_LEN_W-1:0];
            else
               interval = csr_pwdata[INTERVAL_W-1:0];
         end
         if (req_tvalid && req_tready)
            parse_rx_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_result();
      end
      outstanding = expected_results.size();
   end

endmodule

[tb/sv/sync_length_sum_frame_parser_test.sv]
`timescale 1ns / 100ps

module sync_length_sum_frame_parser_test;
   import sljp_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int LONG_HOLD_CYCLES = 300;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [BYTE_W-1:0]       req_tdata   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [TDATA_W-1:0]      rsp_tdata;
   logic [KIND_W-1:0]       rsp_tuser;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int failures;
   int outstanding;
   int results_checked;
   int frames_closed;
   int notices_seen;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_requests      = 0;
   int holds_served       = 0;
   int hold_left          = 0;
   int cycle_count        = 0;
   int bytes_sent         = 0;
   int unsigned cur_max_len = MAX_LEN_RESET;

   always #4 clock = ~clock;

   sync_length_sum_frame_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .failures        (failures),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .frames_closed   (frames_closed),
      .notices_seen    (notices_seen)
   );

   // receiver: random stalls, plus a long hold-off whenever one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int unsigned effective_limit();
      return (cur_max_len > PAYLOAD_LIMIT_DEFAULT) ? PAYLOAD_LIMIT_DEFAULT : cur_max_len;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [BYTE_W-1:0] version, input logic [BYTE_W-1:0] command,
                             input logic [FRAME_LEN_W-1:0] length, input int extra_sync,
                             input bit bad_sum);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] data;
      send_byte(SYNC_FIRST);
      repeat (extra_sync)
         send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(version);
      send_byte(command);
      send_byte(length[15:8]);
      send_byte(length[7:0]);
      sum = SYNC_FIRST + SYNC_SECOND + version + command + length[15:8] + length[7:0];
      // an oversize header ends the frame, the parser resyncs
      if (length != 0 && length > effective_limit())
         return;
      for (int i = 0; i < length; i++) begin
         data = $urandom;
         send_byte(data);
         sum = sum + data;
      end
      if (bad_sum)
         sum = sum ^ $urandom_range(1, 255);
      send_byte(sum);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (outstanding != 0);
      // cover bytes still in flight that report nothing
      repeat (DRAIN_CYCLES)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == CSR_IDX_MAX_LEN)
         cur_max_len = value[MAX_LEN_W-1:0];
   endtask

   // upper bits above each register's width are random and must be dropped
   task automatic configure(input int unsigned max_len, input int unsigned interval,
                            input int sender_pct, input int receiver_pct);
      drain();
      csr_write(CSR_IDX_MAX_LEN, ($urandom << MAX_LEN_W) | max_len);
      csr_write(CSR_IDX_INTERVAL, ($urandom << INTERVAL_W) | interval);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   task automatic random_traffic(input int quota);
      int          stop_at;
      int          pick;
      int          len_pick;
      int unsigned lim;
      int unsigned length;
      stop_at = bytes_sent + quota;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         lim  = effective_limit();
         if (pick < 70) begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 55)
               length = $urandom_range(0, (lim < 8) ? lim : 8);
            else if (len_pick < 75)
               length = $urandom_range(0, (lim < 40) ? lim : 40);
            else if (len_pick < 80)
               length = (lim <= 64) ? lim : $urandom_range(0, 8);
            else if (len_pick < 92)
               length = lim + 1 + $urandom_range(0, 30);
            else
               length = $urandom_range(0, 65535);
            send_frame($urandom, ($urandom_range(0, 3) == 0) ? HEARTBEAT_CMD : $urandom,
                       length, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
                       $urandom_range(0, 4) == 0);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4))
               send_byte(($urandom_range(0, 2) == 0) ? SYNC_FIRST : $urandom);
         end else begin
            // broken header: sync start, then whatever follows
            send_byte(SYNC_FIRST);
            if ($urandom_range(0, 1))
               send_byte(SYNC_SECOND);
            repeat ($urandom_range(1, 5))
               send_byte($urandom);
         end
      end
   endtask

   initial begin
      repeat (6)
         @(posedge clock);
      reset <= 1'b0;

      // directed: stray extremes, broken sync, repeated sync, oversize, heartbeat
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_FIRST);
      send_byte(8'h13);
      send_frame(8'hFF, 8'h01, 16'd2, 1, 1'b0);
      send_frame(8'h07, 8'h80, 16'hFFFF, 0, 1'b0);
      send_frame(8'h00, HEARTBEAT_CMD, 16'd0, 0, 1'b1);
      random_traffic(120);

      configure(0, 2, 70, 0);
      random_traffic(80);

      configure(1023, 255, 0, 70);
      send_frame($urandom, 8'h42, 16'd512, 0, 1'b0);
      send_frame($urandom, 8'h42, 16'd513, 0, 1'b0);
      random_traffic(60);

      configure(5, 1, 13, 13);
      hold_requests++;
      send_frame($urandom, 8'h21, 16'd5, 0, 1'b0);
      random_traffic(100);

      configure(512, 0, 70, 0);
      random_traffic(80);

      configure(37, 3, 0, 70);
      random_traffic(100);

      configure(9, 2, 0, 0);
      random_traffic(100);

      receiver_stall_pct = 0;
      drain();

      $display("Sent %0d bytes under seven register settings and four idle patterns.",
               bytes_sent);
      $display("Checked %0d results: %0d frame ends, %0d heartbeat notices, %0d mismatches.",
               results_checked, frames_closed, notices_seen, failures);
      if (failures == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
